FILE: hw/rtl/tsq_pkg.sv
// Shared types, codes and constants of the task stack block.
package tsq_pkg;

  // Default number of task records held.
  localparam int STACK_DEPTH_DEF = 64;

  // Width of the reported count and depth fields.
  localparam int COUNT_W = 7;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_MAX_OWNER = 1'b0;
  localparam logic [7:0] MAX_OWNER_RESET = 8'd3;

  // Command codes.
  localparam logic [2:0] CMD_PUSH    = 3'd0;
  localparam logic [2:0] CMD_POP     = 3'd1;
  localparam logic [2:0] CMD_FINDMAX = 3'd2;
  localparam logic [2:0] CMD_COUNT   = 3'd3;
  localparam logic [2:0] CMD_REVERSE = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_OWNER = 2'd3;

  // One stored task record.
  typedef struct packed {
    logic [15:0] hours;
    logic [7:0]  owner;
    logic [15:0] tag;
  } tsq_entry_t;

  // One command beat.
  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] hours;
    logic [7:0]  owner_id;
    logic [15:0] task_tag;
  } tsq_cmd_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        out_hours;
    logic [7:0]         out_owner;
    logic [15:0]        out_tag;
    logic [COUNT_W-1:0] owner_count;
    logic [COUNT_W-1:0] depth_now;
  } tsq_result_t;

  // Sequencer to output register: a finished result and its load strobe.
  typedef struct packed {
    logic        load;
    tsq_result_t result;
  } tsq_rsp_t;

endpackage

FILE: hw/rtl/tsq_if.sv
// Valid/ready channel interfaces for command and result beats.
interface tsq_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] hours;
  logic [7:0]  owner_id;
  logic [15:0] task_tag;

  modport source (output valid, command, hours, owner_id, task_tag, input ready);
  modport sink (input valid, command, hours, owner_id, task_tag, output ready);
endinterface

interface tsq_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_hours;
  logic [7:0]  out_owner;
  logic [15:0] out_tag;
  logic [6:0]  owner_count;
  logic [6:0]  depth_now;

  modport source (output valid, status, out_hours, out_owner, out_tag, owner_count,
                  depth_now, input ready);
  modport sink (input valid, status, out_hours, out_owner, out_tag, owner_count,
                depth_now, output ready);
endinterface

FILE: hw/rtl/tsq_ram.sv
// Record store: one write port and two registered read ports.
module tsq_ram #(
  parameter int DEPTH = tsq_pkg::STACK_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  tsq_pkg::tsq_entry_t wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr_a,
  input  logic [AW-1:0]      raddr_b,
  output tsq_pkg::tsq_entry_t rdata_a,
  output tsq_pkg::tsq_entry_t rdata_b
);

  tsq_pkg::tsq_entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports; the data holds while no read is requested.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: hw/rtl/tsq_apb_regs.sv
// Configuration register file behind the APB-style port.
module tsq_apb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsq_pkg::APB_AW-1:0] paddr,
  input  logic [tsq_pkg::APB_DW-1:0] pwdata,
  output logic [tsq_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [7:0]                 max_owner
);

  logic reg_idx;

  // Register index from the word address.
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  // Write on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_owner <= tsq_pkg::MAX_OWNER_RESET;
    end else if (psel && penable && pwrite && pready
                 && (reg_idx == tsq_pkg::REG_MAX_OWNER)) begin
      max_owner <= pwdata[7:0];
    end
  end

  // Read back; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (reg_idx == tsq_pkg::REG_MAX_OWNER) begin
      prdata = {{(tsq_pkg::APB_DW - 8){1'b0}}, max_owner};
    end
  end

endmodule

FILE: hw/rtl/tsq_seq.sv
// Command sequencer with the shared compare unit that walks the store.
module tsq_seq #(
  parameter int STACK_DEPTH = tsq_pkg::STACK_DEPTH_DEF,
  parameter int AW          = $clog2(STACK_DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  tsq_pkg::tsq_cmd_t   cmd_item,
  input  logic [7:0]          max_owner,
  input  logic                res_free,
  output tsq_pkg::tsq_rsp_t   rsp,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output tsq_pkg::tsq_entry_t ram_wdata,
  output logic                ram_re,
  output logic [AW-1:0]       ram_raddr_a,
  output logic [AW-1:0]       ram_raddr_b,
  input  tsq_pkg::tsq_entry_t ram_rdata_a,
  input  tsq_pkg::tsq_entry_t ram_rdata_b
);

  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int WW = (FW > tsq_pkg::COUNT_W) ? FW : tsq_pkg::COUNT_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_START  = 8'b0000_0010,
    S_POPRD  = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_REVRD  = 8'b0001_0000,
    S_REVWLO = 8'b0010_0000,
    S_REVWHI = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t            state;
  tsq_pkg::tsq_cmd_t cmd_q;
  logic [FW-1:0]     fill;
  logic [FW-1:0]     cnt;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     lo;
  logic [AW-1:0]     hi;
  logic              more;
  logic              dvalid;
  logic              first;
  logic [1:0]        res_status;
  logic [15:0]       res_hours;
  logic [7:0]        res_owner;
  logic [15:0]       res_tag;

  logic          owner_ok;
  logic          full;
  logic          is_find;
  logic [15:0]   cmp_a;
  logic [15:0]   cmp_b;
  logic          cmp_gt;
  logic          cmp_eq;
  logic          hit;
  logic [AW-1:0] top_addr;
  logic [WW-1:0] cnt_w;
  logic [WW-1:0] fill_w;

  assign owner_ok = (cmd_q.owner_id != 8'd0) && (cmd_q.owner_id <= max_owner);
  assign full     = (fill == FW'(STACK_DEPTH));
  assign top_addr = AW'(fill - FW'(1));
  assign is_find  = (cmd_q.command == tsq_pkg::CMD_FINDMAX);

  // Shared compare unit: hours against the best so far, or owner against the key.
  always_comb begin
    if (is_find) begin
      cmp_a = ram_rdata_a.hours;
      cmp_b = res_hours;
    end else begin
      cmp_a = {8'd0, ram_rdata_a.owner};
      cmp_b = {8'd0, cmd_q.owner_id};
    end
    cmp_gt = (cmp_a > cmp_b);
    cmp_eq = (cmp_a == cmp_b);
    hit    = is_find ? (first || cmp_gt) : cmp_eq;
  end

  // Store port control for each step.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = lo;
    ram_wdata   = ram_rdata_b;
    ram_re      = 1'b0;
    ram_raddr_a = idx;
    ram_raddr_b = hi;
    case (state)
      S_START: begin
        if ((cmd_q.command == tsq_pkg::CMD_PUSH) && owner_ok && !full) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(fill);
          ram_wdata = '{hours: cmd_q.hours, owner: cmd_q.owner_id, tag: cmd_q.task_tag};
        end
        if ((cmd_q.command == tsq_pkg::CMD_POP) && (fill != '0)) begin
          ram_re      = 1'b1;
          ram_raddr_a = top_addr;
        end
      end
      S_SCAN: begin
        ram_re = more;
      end
      S_REVRD: begin
        ram_re      = 1'b1;
        ram_raddr_a = lo;
      end
      S_REVWLO: begin
        ram_we    = 1'b1;
        ram_waddr = lo;
        ram_wdata = ram_rdata_b;
      end
      S_REVWHI: begin
        ram_we    = 1'b1;
        ram_waddr = hi;
        ram_wdata = ram_rdata_a;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= '0;
      more   <= 1'b0;
      dvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd_item;
            state <= S_START;
          end
        end
        S_START: begin
          res_status <= tsq_pkg::ST_OK;
          res_hours  <= '0;
          res_owner  <= '0;
          res_tag    <= '0;
          cnt        <= '0;
          first      <= 1'b1;
          more       <= 1'b0;
          dvalid     <= 1'b0;
          state      <= S_DONE;
          case (cmd_q.command)
            tsq_pkg::CMD_PUSH: begin
              if (!owner_ok) begin
                res_status <= tsq_pkg::ST_BAD_OWNER;
              end else if (full) begin
                res_status <= tsq_pkg::ST_FULL;
              end else begin
                fill <= fill + FW'(1);
              end
            end
            tsq_pkg::CMD_POP: begin
              if (fill == '0) begin
                res_status <= tsq_pkg::ST_EMPTY;
              end else begin
                fill  <= fill - FW'(1);
                state <= S_POPRD;
              end
            end
            tsq_pkg::CMD_FINDMAX, tsq_pkg::CMD_COUNT: begin
              if (fill == '0) begin
                if (is_find) begin
                  res_status <= tsq_pkg::ST_EMPTY;
                end
              end else begin
                idx   <= top_addr;
                more  <= 1'b1;
                state <= S_SCAN;
              end
            end
            tsq_pkg::CMD_REVERSE: begin
              if (fill > FW'(1)) begin
                lo    <= '0;
                hi    <= top_addr;
                state <= S_REVRD;
              end
            end
            default: begin
            end
          endcase
        end
        S_POPRD: begin
          res_hours <= ram_rdata_a.hours;
          res_owner <= ram_rdata_a.owner;
          res_tag   <= ram_rdata_a.tag;
          state     <= S_DONE;
        end
        S_SCAN: begin
          // Reads go from the top down; each one is judged in the cycle after its read.
          dvalid <= more;
          if (more) begin
            if (idx == '0) begin
              more <= 1'b0;
            end else begin
              idx <= idx - AW'(1);
            end
          end
          if (dvalid) begin
            first <= 1'b0;
            if (hit) begin
              if (is_find) begin
                res_hours <= ram_rdata_a.hours;
                res_owner <= ram_rdata_a.owner;
                res_tag   <= ram_rdata_a.tag;
              end else begin
                cnt <= cnt + FW'(1);
              end
            end
          end
          if (!more && !dvalid) begin
            state <= S_DONE;
          end
        end
        S_REVRD: begin
          state <= S_REVWLO;
        end
        S_REVWLO: begin
          state <= S_REVWHI;
        end
        S_REVWHI: begin
          // Step both ends inwards and stop once they meet or cross.
          lo <= lo + AW'(1);
          hi <= hi - AW'(1);
          if (({1'b0, lo} + (AW + 1)'(2)) < {1'b0, hi}) begin
            state <= S_REVRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_ready = (state == S_IDLE);

  // Result beat, counts reported in their low bits.
  assign cnt_w  = WW'(cnt);
  assign fill_w = WW'(fill);
  always_comb begin
    rsp.load               = (state == S_DONE) && res_free;
    rsp.result.status      = res_status;
    rsp.result.out_hours   = res_hours;
    rsp.result.out_owner   = res_owner;
    rsp.result.out_tag     = res_tag;
    rsp.result.owner_count = cnt_w[tsq_pkg::COUNT_W-1:0];
    rsp.result.depth_now   = fill_w[tsq_pkg::COUNT_W-1:0];
  end

endmodule

FILE: hw/rtl/task_stack_with_queries.sv
// One command is in work at a time. Find-max and count walk the stored records from the top
// down, one read per cycle through read port a; reverse swaps the records pairwise from both
// ends, reading each pair together and writing the two records back one after the other.
// A new command is taken while the previous result still waits in the output register.
// Reset empties the stack and sets the largest owner id to 3; the store itself is not
// cleared, since only written entries are ever read.
module task_stack_with_queries #(
  parameter int STACK_DEPTH = tsq_pkg::STACK_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsq_pkg::APB_AW-1:0] paddr,
  input  logic [tsq_pkg::APB_DW-1:0] pwdata,
  output logic [tsq_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  tsq_cmd_if.sink                    cmd,
  tsq_res_if.source                  res
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic                 res_free;
  logic [7:0]           max_owner;
  tsq_pkg::tsq_cmd_t    cmd_item;
  tsq_pkg::tsq_rsp_t    rsp;
  tsq_pkg::tsq_result_t out_data;
  logic                 out_valid;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  tsq_pkg::tsq_entry_t  ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr_a;
  logic [AW-1:0]        ram_raddr_b;
  tsq_pkg::tsq_entry_t  ram_rdata_a;
  tsq_pkg::tsq_entry_t  ram_rdata_b;

  tsq_apb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_owner (max_owner)
  );

  assign cmd_item = '{command:  cmd.command,
                      hours:    cmd.hours,
                      owner_id: cmd.owner_id,
                      task_tag: cmd.task_tag};

  tsq_seq #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_item    (cmd_item),
    .max_owner   (max_owner),
    .res_free    (res_free),
    .rsp         (rsp),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_a (ram_rdata_a),
    .ram_rdata_b (ram_rdata_b)
  );

  tsq_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // Output register: holds one result beat until it is taken.
  assign res_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp.load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.load) begin
      out_data <= rsp.result;
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_data.status;
  assign res.out_hours   = out_data.out_hours;
  assign res.out_owner   = out_data.out_owner;
  assign res.out_tag     = out_data.out_tag;
  assign res.owner_count = out_data.owner_count;
  assign res.depth_now   = out_data.depth_now;

  // A new result is loaded only when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    rsp.load |-> (!out_valid || res.ready))
    else $error("result loaded over a beat still waiting");

  // Once a command is taken, no other is taken in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("command taken while another is in work");

  // A command taken from idle cannot have its result shown in the next cycle.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && !res.valid) |=> !res.valid)
    else $error("result appeared too early");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result pending after reset");

endmodule

FILE: bench/tsq_stack_monitor.sv
// Monitor of the task stack: tracks the stack, predicts each result beat and compares.
module tsq_stack_monitor
  import tsq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  tsq_cmd_if                cmd_mon,
  tsq_res_if                res_mon,
  output int                mismatches,
  output int                outstanding,
  output int                results_checked,
  output int                status_seen [4],
  output int                deepest
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam logic [APB_AW-1:0] MAX_OWNER_ADDR = {REG_MAX_OWNER, 2'b00};
  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the stack and of the owner limit.
  tsq_entry_t  stack_mem [DEPTH];
  int          stack_fill;
  logic [7:0]  owner_limit;

  // Predicted result beats, oldest first.
  tsq_result_t awaited_results [$];

  int miss_count;
  int result_count;
  int top_fill;
  int status_count [4];

  // Applies one command to the shadow stack and returns the result it should give.
  function automatic tsq_result_t step_task_stack(tsq_cmd_t beat);
    tsq_result_t r;
    tsq_entry_t  swap;
    int          best;
    int          lo;
    int          hi;
    r = '0;
    case (beat.command)
      CMD_PUSH: begin
        if (beat.owner_id == 8'd0 || beat.owner_id > owner_limit) begin
          r.status = ST_BAD_OWNER;
        end else if (stack_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_mem[stack_fill].hours = beat.hours;
          stack_mem[stack_fill].owner = beat.owner_id;
          stack_mem[stack_fill].tag   = beat.task_tag;
          stack_fill++;
        end
      end
      CMD_POP: begin
        if (stack_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          stack_fill--;
          r.out_hours = stack_mem[stack_fill].hours;
          r.out_owner = stack_mem[stack_fill].owner;
          r.out_tag   = stack_mem[stack_fill].tag;
        end
      end
      CMD_FINDMAX: begin
        if (stack_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // Walk down from the top; only a strictly larger value moves the pick, so ties
          // go to the entry nearest the top.
          best = stack_fill - 1;
          for (int i = stack_fill - 1; i > 0; i--) begin
            if (stack_mem[i-1].hours > stack_mem[best].hours) best = i - 1;
          end
          r.out_hours = stack_mem[best].hours;
          r.out_owner = stack_mem[best].owner;
          r.out_tag   = stack_mem[best].tag;
        end
      end
      CMD_COUNT: begin
        for (int i = 0; i < stack_fill; i++) begin
          if (stack_mem[i].owner == beat.owner_id) r.owner_count = r.owner_count + 1'b1;
        end
      end
      CMD_REVERSE: begin
        lo = 0;
        hi = stack_fill - 1;
        while (lo < hi) begin
          swap          = stack_mem[lo];
          stack_mem[lo] = stack_mem[hi];
          stack_mem[hi] = swap;
          lo++;
          hi--;
        end
      end
      default: begin
        // Spare command codes leave everything as it is.
      end
    endcase
    r.depth_now = COUNT_W'(stack_fill);
    return r;
  endfunction

  // Compares one field and reports the first few differences.
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      miss_count++;
      if (miss_count <= REPORT_LIMIT)
        $display("result beat %0d: %s expected %0d, got %0d", result_count, name, want, got);
    end
  endtask

  // Result beats are checked before a command beat of the same edge is predicted,
  // since a result always belongs to an earlier command.
  always @(posedge clk) begin : track
    tsq_result_t want;
    tsq_cmd_t    beat;
    if (rst) begin
      stack_fill  = 0;
      owner_limit = MAX_OWNER_RESET;
      awaited_results.delete();
      miss_count   = 0;
      result_count = 0;
      top_fill     = 0;
      foreach (status_count[i]) status_count[i] = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == MAX_OWNER_ADDR)
        owner_limit = pwdata[7:0];

      if (res_mon.valid && res_mon.ready) begin
        result_count++;
        if (awaited_results.size() == 0) begin
          miss_count++;
          if (miss_count <= REPORT_LIMIT)
            $display("result beat %0d arrived with no command waiting for it", result_count);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, res_mon.status);
          check_field("out_hours", want.out_hours, res_mon.out_hours);
          check_field("out_owner", want.out_owner, res_mon.out_owner);
          check_field("out_tag", want.out_tag, res_mon.out_tag);
          check_field("owner_count", want.owner_count, res_mon.owner_count);
          check_field("depth_now", want.depth_now, res_mon.depth_now);
          status_count[want.status]++;
        end
      end

      if (cmd_mon.valid && cmd_mon.ready) begin
        beat.command  = cmd_mon.command;
        beat.hours    = cmd_mon.hours;
        beat.owner_id = cmd_mon.owner_id;
        beat.task_tag = cmd_mon.task_tag;
        awaited_results.push_back(step_task_stack(beat));
        if (stack_fill > top_fill) top_fill = stack_fill;
      end
    end

    mismatches      <= miss_count;
    outstanding     <= awaited_results.size();
    results_checked <= result_count;
    deepest         <= top_fill;
    foreach (status_count[i]) status_seen[i] <= status_count[i];
  end

endmodule

FILE: bench/tb_task_stack_with_queries.sv
// Top of the task stack testbench: clock, reset, stimulus, stalls and verdict.
module tb_task_stack_with_queries
  import tsq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_AW-1:0] MAX_OWNER_ADDR = {REG_MAX_OWNER, 2'b00};
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  // Cycles with no beat and no register write before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  // Drain time at the end, above the slowest command on a full stack.
  localparam int END_WAIT = 200;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  tsq_cmd_if cmd_bus ();
  tsq_res_if res_bus ();

  int mismatches;
  int outstanding;
  int results_checked;
  int status_seen [4];
  int deepest;

  int         gap_max = 10;
  int         quiet_cycles = 0;
  logic [7:0] owner_limit = MAX_OWNER_RESET;
  logic [7:0] random_limit;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task_stack_with_queries dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cmd(cmd_bus), .res(res_bus)
  );

  tsq_stack_monitor monitor (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .cmd_mon(cmd_bus), .res_mon(res_bus),
    .mismatches, .outstanding, .results_checked, .status_seen, .deepest
  );

  // Writes the largest accepted owner id: setup cycle, then access until pready.
  task automatic write_max_owner(logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_OWNER_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    owner_limit = value;
  endtask

  // Offers one command beat after a random gap and holds it until taken.
  task automatic send_command(logic [2:0] op, logic [15:0] hrs, logic [7:0] own,
                              logic [15:0] tag);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid    <= 1'b1;
    cmd_bus.command  <= op;
    cmd_bus.hours    <= hrs;
    cmd_bus.owner_id <= own;
    cmd_bus.task_tag <= tag;
    do @(posedge clk); while (!cmd_bus.ready);
  endtask

  // Stops sending and waits until every predicted result beat has come back.
  task automatic settle();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mostly a valid owner for the current limit, now and then any byte; any byte when the limit is zero.
  function automatic logic [7:0] pick_owner();
    if (owner_limit == 8'd0 || $urandom_range(9, 0) == 0) return 8'($urandom_range(255, 0));
    return 8'($urandom_range(owner_limit, 1));
  endfunction

  // Small values make ties for find-max likely; extremes and full-range values fill the rest.
  function automatic logic [15:0] pick_hours();
    case ($urandom_range(3, 0))
      0:       return 16'($urandom_range(3, 0));
      1:       return ($urandom_range(1, 0) != 0) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random commands with a chosen share of pushes; a few spare codes are mixed in.
  task automatic random_commands(int count, int push_pct);
    int         roll;
    logic [2:0] op;
    repeat (count) begin
      roll = $urandom_range(99, 0);
      if (roll < push_pct) begin
        op = CMD_PUSH;
      end else if (roll >= 97) begin
        op = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
      end else begin
        case ($urandom_range(3, 0))
          0:       op = CMD_POP;
          1:       op = CMD_FINDMAX;
          2:       op = CMD_COUNT;
          default: op = CMD_REVERSE;
        endcase
      end
      send_command(op, pick_hours(), pick_owner(), 16'($urandom));
    end
  endtask

  // The result side draws a stall before each beat it takes.
  initial begin
    int hold;
    res_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = $urandom_range(gap_max, 0);
      if (hold > 0) begin
        res_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("tb_task_stack_with_queries: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    cmd_bus.valid    <= 1'b0;
    cmd_bus.command  <= CMD_PUSH;
    cmd_bus.hours    <= '0;
    cmd_bus.owner_id <= '0;
    cmd_bus.task_tag <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset owner limit of three.
    send_command(CMD_POP, 16'h0000, 8'd0, 16'h0000);
    send_command(CMD_FINDMAX, 16'h0000, 8'd0, 16'h0000);
    send_command(CMD_COUNT, 16'h0000, 8'd1, 16'h0000);
    send_command(CMD_REVERSE, 16'h0000, 8'd0, 16'h0000);
    send_command(CMD_PUSH, 16'hFFFF, 8'd0, 16'hFFFF);
    send_command(CMD_PUSH, 16'h1111, 8'd4, 16'h2222);
    send_command(CMD_PUSH, 16'hFFFF, 8'd1, 16'hFFFF);
    send_command(CMD_REVERSE, 16'h0000, 8'd0, 16'h0000);
    send_command(CMD_PUSH, 16'h0000, 8'd3, 16'h0000);
    send_command(CMD_PUSH, 16'hFFFF, 8'd2, 16'hA5A5);
    send_command(CMD_PUSH, 16'h8000, 8'd3, 16'h5A5A);
    send_command(CMD_FINDMAX, 16'h0000, 8'd0, 16'h0000);
    send_command(CMD_COUNT, 16'h0000, 8'd3, 16'h0000);
    send_command(CMD_COUNT, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_command(CMD_COUNT, 16'h0000, 8'd0, 16'h0000);
    send_command(CMD_REVERSE, 16'h0000, 8'd0, 16'h0000);
    send_command(CMD_FINDMAX, 16'h0000, 8'd0, 16'h0000);
    for (int k = CMD_SPARE_FIRST; k <= CMD_SPARE_LAST; k++)
      send_command(3'(k), 16'hFFFF, 8'hFF, 16'hFFFF);
    repeat (5) send_command(CMD_POP, 16'h0000, 8'd0, 16'h0000);

    // Widest owner range; pushes dominate so the stack fills and overflows.
    settle();
    write_max_owner(8'hFF);
    random_commands(150, 60);

    // Single owner, with pushes in the minority.
    settle();
    write_max_owner(8'd1);
    random_commands(120, 30);

    // No owner is valid, so every push is refused while pops drain the stack.
    settle();
    write_max_owner(8'd0);
    random_commands(60, 50);

    // Random limit, with every outstanding result drained half way through.
    settle();
    random_limit = 8'($urandom_range(254, 2));
    write_max_owner(random_limit);
    random_commands(75, 55);
    settle();
    random_commands(75, 55);

    // Back to the reset limit: a stretch with no stalls, then stalls again.
    settle();
    write_max_owner(MAX_OWNER_RESET);
    gap_max = 0;
    random_commands(100, 50);
    gap_max = 10;
    random_commands(170, 45);

    settle();
    repeat (END_WAIT) @(posedge clk);

    $display("%0d result beats checked: %0d ok, %0d empty, %0d full, %0d bad owner",
             results_checked, status_seen[ST_OK], status_seen[ST_EMPTY],
             status_seen[ST_FULL], status_seen[ST_BAD_OWNER]);
    $display("owner limits 3, 255, 1, 0, %0d and 3 used; deepest stack %0d of %0d",
             random_limit, deepest, STACK_DEPTH_DEF);
    if (mismatches == 0) begin
      $display("tb_task_stack_with_queries: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_task_stack_with_queries: errors");
    end
    $finish;
  end

endmodule
